/* rtl/hpil_pkg.sv */
// hpil_pkg: shared types, constants and the hex digit decode for the hex page image loader.
// No dependencies; every other file in rtl/ imports it.
package hpil_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned AddrW = 20;
  localparam int unsigned PageW = 16;
  localparam int unsigned LineW = 8;
  localparam int unsigned ChipW = 3;

  localparam logic [CharW-1:0] CharZero = 8'h30;  // '0'
  localparam logic [CharW-1:0] CharNine = 8'h39;  // '9'
  localparam logic [CharW-1:0] CharEndPage = 8'h78;  // 'x'
  localparam logic [CharW-1:0] CharNextChip = 8'h7a;  // 'z'

  localparam logic [PageW-1:0] PageMask = 16'hff80;
  localparam logic [PageW-1:0] LineMask = 16'h007f;
  localparam logic [AddrW-1:0] AddrOffset = 20'd8;
  localparam logic [ChipW-1:0] ChipLimit = 3'd4;

  typedef struct packed {
    logic [AddrW-1:0] write_address;
    logic [CharW-1:0] write_char;
    logic             chip_overflow;
  } write_req_t;

  // digits decode directly; anything else is (ch - 'a' + 10) mod 16 = (ch + 9) mod 16
  function automatic logic [3:0] hex_nibble(input logic [CharW-1:0] ch);
    logic [3:0] nib;
    if (ch >= CharZero && ch <= CharNine) begin
      nib = ch[3:0];
    end else begin
      nib = ch[3:0] + 4'd9;
    end
    return nib;
  endfunction

endpackage

/* rtl/hpil_char_if.sv */
// hpil_char_if: valid/ready channel carrying one source text character per request.
// Depends on hpil_pkg.
interface hpil_char_if;
  import hpil_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

/* rtl/hpil_write_if.sv */
// hpil_write_if: valid/ready channel carrying one image write request.
// Depends on hpil_pkg.
interface hpil_write_if;
  import hpil_pkg::*;

  logic             valid;
  logic             ready;
  logic [AddrW-1:0] write_address;
  logic [CharW-1:0] write_char;
  logic             chip_overflow;

  modport source (output valid, output write_address, output write_char,
                  output chip_overflow, input ready);
  modport sink (input valid, input write_address, input write_char,
                input chip_overflow, output ready);
endinterface

/* rtl/hex_page_image_loader.sv */
// hex_page_image_loader: parses a hex text program image one character per cycle while
// writes does not stall, and issues byte writes into the program image.
//
// Channels: chars (sink) takes one ASCII character per request; writes (source) gives
// at most one write request per character: write_address, write_char and
// chip_overflow (set, with address and data zero, once more than four chip markers
// have been seen). Page digits, line digits and separators give no request.
//
// Path: a character accepted on chars passes the input register and then the result
// register before its write request shows on writes.
// Throughput: one character per cycle while writes does not stall; the parser state
// update is a single register step, so back-to-back characters flow with no bubbles.
//
// Reset (rst, synchronous) returns the parser to the page digit phase with page, line
// and chip count at zero and drops any pending request.
// When writes stalls, the result register holds its request; the input register
// still moves on characters that give no request, and chars.ready drops only when a
// character waiting in the input register needs the occupied result register.
// Depends on hpil_pkg, hpil_char_if, hpil_write_if, hpil_parser, hpil_out_reg.
module hex_page_image_loader (
  input logic         clk,
  input logic         rst,
  hpil_char_if.sink   chars,
  hpil_write_if.source writes
);
  import hpil_pkg::*;

  logic             in_valid;
  logic [CharW-1:0] in_char_q;
  logic             out_free;
  logic             advance;
  logic             req_valid;
  write_req_t       req;

  assign advance = in_valid && (out_free || !req_valid);
  assign chars.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_char_q <= chars.in_char;
    end
  end

  hpil_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .ch        (in_char_q),
    .req_valid (req_valid),
    .req       (req)
  );

  hpil_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (advance && req_valid),
    .data (req),
    .free (out_free),
    .wr   (writes)
  );

endmodule

/* rtl/hpil_parser.sv */
// hpil_parser: record parser state (phase, digit position, page, line, chip) and the
// combinational write request for the current character. Depends on hpil_pkg.
module hpil_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [hpil_pkg::CharW-1:0] ch,
  output logic                      req_valid,
  output hpil_pkg::write_req_t      req
);
  import hpil_pkg::*;

  typedef enum logic [2:0] {
    PH_PAGE = 3'd0,
    PH_LINE = 3'd1,
    PH_DATA = 3'd2,
    PH_SEP  = 3'd3,
    PH_X    = 3'd4
  } phase_t;

  phase_t           phase, phase_next;
  logic [1:0]       digit_count, digit_count_next;
  logic [PageW-1:0] page_value, page_value_next;
  logic [LineW-1:0] line_value, line_value_next;
  logic [ChipW-1:0] chip_count, chip_count_next;

  logic [3:0]       nib;
  logic [PageW-1:0] base;
  logic [AddrW-1:0] base_x10;

  function automatic logic [PageW-1:0] page_insert(input logic [PageW-1:0] pg,
                                                   input logic [1:0] pos,
                                                   input logic [3:0] n);
    logic [PageW-1:0] r;
    case (pos)
      2'd0: r = {n, 12'h000};
      2'd1: r = {pg[15:12], n, pg[7:0]};
      2'd2: r = {pg[15:8], n, pg[3:0]};
      2'd3: r = {pg[15:4], n};
      default: r = pg;
    endcase
    return r;
  endfunction

  assign nib = hex_nibble(ch);
  assign base = (page_value & PageMask) | ({8'h00, line_value} & LineMask);
  assign base_x10 = {1'b0, base, 3'b000} + {3'b000, base, 1'b0};

  always_comb begin
    phase_next = phase;
    digit_count_next = digit_count;
    page_value_next = page_value;
    line_value_next = line_value;
    chip_count_next = chip_count;
    req_valid = 1'b0;
    req = '0;
    case (phase)
      PH_LINE: begin
        if (digit_count == 2'd0) begin
          line_value_next = {nib, 4'h0};
          digit_count_next = 2'd1;
        end else begin
          line_value_next = {line_value[7:4], nib};
          phase_next = PH_DATA;
          digit_count_next = 2'd0;
        end
      end
      PH_DATA: begin
        req_valid = 1'b1;
        if (chip_count > ChipLimit) begin
          req.chip_overflow = 1'b1;
        end else begin
          req.write_address = base_x10 + AddrOffset - {16'd0, chip_count, 1'b0}
                              + {19'd0, digit_count[0]};
          req.write_char = ch;
        end
        if (!digit_count[0]) begin
          digit_count_next = 2'd1;
        end else begin
          phase_next = PH_SEP;
          digit_count_next = 2'd0;
        end
      end
      PH_SEP: begin
        digit_count_next = 2'd0;
        if (ch == CharEndPage) begin
          phase_next = PH_X;
        end else begin
          // first line digit of the next group
          line_value_next = {nib, 4'h0};
          digit_count_next = 2'd1;
          phase_next = PH_LINE;
        end
      end
      PH_X: begin
        phase_next = PH_PAGE;
        digit_count_next = 2'd0;
        if (ch == CharNextChip) begin
          if (chip_count <= ChipLimit) chip_count_next = chip_count + 3'd1;
        end else begin
          page_value_next = page_insert(page_value, 2'd0, nib);
          digit_count_next = 2'd1;
        end
      end
      default: begin
        phase_next = PH_PAGE;
        page_value_next = page_insert(page_value, digit_count, nib);
        if (digit_count == 2'd3) begin
          phase_next = PH_LINE;
          digit_count_next = 2'd0;
        end else begin
          digit_count_next = digit_count + 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PAGE;
      digit_count <= 2'd0;
      page_value <= '0;
      line_value <= '0;
      chip_count <= '0;
    end else if (step) begin
      phase <= phase_next;
      digit_count <= digit_count_next;
      page_value <= page_value_next;
      line_value <= line_value_next;
      chip_count <= chip_count_next;
    end
  end

endmodule

/* rtl/hpil_out_reg.sv */
// hpil_out_reg: result register driving the write channel; holds a request while the
// receiver stalls and reports when it can take a new one. Depends on hpil_pkg, hpil_write_if.
module hpil_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  hpil_pkg::write_req_t data,
  output logic                 free,
  hpil_write_if.source         wr
);
  import hpil_pkg::*;

  logic       valid;
  write_req_t held;

  assign free = !valid || wr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (wr.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  assign wr.valid = valid;
  assign wr.write_address = held.write_address;
  assign wr.write_char = held.write_char;
  assign wr.chip_overflow = held.chip_overflow;

endmodule
